FILE: design/vn2d_pkg.sv
// Shared constants for the 2D value noise core: field widths, register codes,
// reset values and the fixed 256-entry permutation table.
// No dependencies.
package vn2d_pkg;

   localparam int COORD_W     = 24;
   localparam int FRAC_W      = 16;
   localparam int IDX_W       = 8;
   localparam int OUT_W       = 16;
   localparam int MAX_OCTAVES = 8;
   localparam int TABLE_SIZE  = 256;
   localparam int OCT_W       = 4;
   localparam int SEED_W      = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVES = 2'd1;

   localparam logic [SEED_W-1:0] SEED_RESET = 8'd0;
   localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd4;

   // 3.0 in Q2.16, the constant term of the smoothstep factor (3 - 2s)
   localparam logic [17:0] SMOOTH_K = 18'd196608;

   // quotient is known to stay below 2^16; two bits resolved per stage
   localparam int QUO_BITS   = 16;
   localparam int DIV_STAGES = 8;

   localparam logic [IDX_W-1:0] PERM_TABLE [TABLE_SIZE] = '{
      8'd208, 8'd34, 8'd231, 8'd213, 8'd32, 8'd248, 8'd233, 8'd56,
      8'd161, 8'd78, 8'd24, 8'd140, 8'd71, 8'd48, 8'd140, 8'd254,
      8'd245, 8'd255, 8'd247, 8'd247, 8'd40, 8'd185, 8'd248, 8'd251,
      8'd245, 8'd28, 8'd124, 8'd204, 8'd204, 8'd76, 8'd36, 8'd1,
      8'd107, 8'd28, 8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
      8'd167, 8'd204, 8'd9, 8'd92, 8'd217, 8'd54, 8'd239, 8'd174,
      8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
      8'd167, 8'd44, 8'd43, 8'd77, 8'd180, 8'd204, 8'd8, 8'd81,
      8'd70, 8'd223, 8'd11, 8'd38, 8'd24, 8'd254, 8'd210, 8'd210,
      8'd177, 8'd32, 8'd81, 8'd195, 8'd243, 8'd125, 8'd8, 8'd169,
      8'd112, 8'd32, 8'd97, 8'd53, 8'd195, 8'd13, 8'd203, 8'd9,
      8'd47, 8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
      8'd181, 8'd235, 8'd193, 8'd206, 8'd70, 8'd180, 8'd174, 8'd0,
      8'd167, 8'd181, 8'd41, 8'd164, 8'd30, 8'd116, 8'd127, 8'd198,
      8'd245, 8'd146, 8'd87, 8'd224, 8'd149, 8'd206, 8'd57, 8'd4,
      8'd192, 8'd210, 8'd65, 8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
      8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40, 8'd35, 8'd195,
      8'd38, 8'd58, 8'd65, 8'd207, 8'd215, 8'd253, 8'd65, 8'd85,
      8'd208, 8'd76, 8'd62, 8'd3, 8'd237, 8'd55, 8'd89, 8'd232,
      8'd50, 8'd217, 8'd64, 8'd244, 8'd157, 8'd199, 8'd121, 8'd252, 8'd90,
      8'd17, 8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234,
      8'd177, 8'd73, 8'd174, 8'd193, 8'd100, 8'd192,
      8'd143, 8'd97, 8'd53, 8'd145, 8'd135, 8'd19, 8'd103, 8'd13,
      8'd90, 8'd135, 8'd151, 8'd199, 8'd91, 8'd239, 8'd247, 8'd33,
      8'd39, 8'd145, 8'd101, 8'd120, 8'd99, 8'd3, 8'd186, 8'd86,
      8'd99, 8'd41, 8'd237, 8'd203, 8'd111, 8'd79, 8'd220, 8'd135,
      8'd158, 8'd42, 8'd30, 8'd154, 8'd120, 8'd67, 8'd87, 8'd167,
      8'd135, 8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,
      8'd233, 8'd58, 8'd129, 8'd233, 8'd142, 8'd39, 8'd128, 8'd211,
      8'd118, 8'd137, 8'd139, 8'd255, 8'd114, 8'd20, 8'd218,
      8'd113, 8'd154, 8'd27, 8'd127, 8'd246, 8'd250, 8'd1, 8'd8,
      8'd198, 8'd250, 8'd209, 8'd92, 8'd222, 8'd173, 8'd21, 8'd88,
      8'd102, 8'd219
   };

endpackage

FILE: design/value_noise_2d_octaves_core.sv
// Fractal 2D value noise core: one octave lane per octave, weighted sum and
// a pipelined normalising divider.
// Depends on vn2d_pkg.

// Takes one Q8.16 (x, y) word per cycle and returns one Q0.16 noise word per
// word, in order, through 17 register stages. Every octave has its own lane
// of table lookups and blend multipliers, so the octave count does not change
// the throughput; the depth is set by the lane stages, the weighted-sum tree
// and the eight stages of the divider that resolve two quotient bits each.
// The whole pipeline holds while a finished word waits on rsp_ready, and
// takes a new word in the cycle that word is taken. Registers (seed, octave
// count) are to be written only with the pipeline empty; an octave count of
// 0 acts as 1 and one above MaxOctaves as MaxOctaves.
module value_noise_2d_octaves_core #(
   parameter int MaxOctaves = vn2d_pkg::MAX_OCTAVES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [vn2d_pkg::COORD_W-1:0]         req_x_coord,
   input  logic [vn2d_pkg::COORD_W-1:0]         req_y_coord,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [vn2d_pkg::OUT_W-1:0]           rsp_noise_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vn2d_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vn2d_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW      = vn2d_pkg::COORD_W + MaxOctaves;  // weighted sum
   localparam int RW      = AW - 8;                          // sum / 256
   localparam int NW      = $clog2(MaxOctaves + 1);
   localparam int NG      = (MaxOctaves + 3) / 4;
   localparam int LANE_ST = 7;                               // lane stages incl. term
   localparam int DIV0    = LANE_ST + 2;                     // first divider stage
   localparam int NST     = DIV0 + vn2d_pkg::DIV_STAGES;
   localparam int FW      = vn2d_pkg::FRAC_W;
   localparam int IW      = vn2d_pkg::IDX_W;

   // ---------------------------------------------------------------- registers
   logic [vn2d_pkg::SEED_W-1:0] seed_ff;
   logic [vn2d_pkg::OCT_W-1:0]  oct_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= vn2d_pkg::SEED_RESET;
         oct_ff  <= vn2d_pkg::OCT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            vn2d_pkg::CSR_SEED:    seed_ff <= csr_wdata[vn2d_pkg::SEED_W-1:0];
            vn2d_pkg::CSR_OCTAVES: oct_ff  <= csr_wdata[vn2d_pkg::OCT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped octave count and divisor 2^n - 1
   logic [NW-1:0] ncl;
   logic [RW-1:0] dvs;

   always_comb begin
      if (oct_ff == '0) begin
         ncl = NW'(1);
      end else if (int'(oct_ff) > MaxOctaves) begin
         ncl = NW'(MaxOctaves);
      end else begin
         ncl = NW'(oct_ff);
      end
      dvs = (RW'(1) << ncl) - RW'(1);
   end

   // ---------------------------------------------------------------- control
   logic [NST-1:0] vld_ff;
   logic           adv;

   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------- lanes
   logic [AW-1:0] term_ff [NG*4];

   function automatic logic [23:0] blend8(input logic [IW-1:0] a, input logic [IW-1:0] b,
                                           input logic [FW-1:0] w);
      logic [IW-1:0]    d;
      logic [IW+FW-1:0] p;
      begin
         d = (b >= a) ? b - a : a - b;
         p = (IW+FW)'(d) * (IW+FW)'(w);
         blend8 = (b >= a) ? {a, 16'h0} + p : {a, 16'h0} - p;
      end
   endfunction

   for (genvar k = 0; k < NG*4; k++) begin : g_lane
      if (k < MaxOctaves) begin : g_used
         logic [vn2d_pkg::COORD_W-1:0] xs, ys;
         logic [IW-1:0]  xi, yi;
         logic [FW-1:0]  sx, sy;
         logic [31:0]    sqx_p, sqy_p;
         logic [33:0]    wx_p, wy_p;
         logic [IW-1:0]  ra_in, rb_in;

         // stage 1: row lookups and squares of the fractions
         logic [IW-1:0]  xi_ff, ra_ff, rb_ff;
         logic [FW-1:0]  sx_ff, sy_ff, sqx_ff, sqy_ff;
         // stage 2: corner lookups and smoothstep weights
         logic [IW-1:0]  c00_ff, c10_ff, c01_ff, c11_ff;
         logic [FW-1:0]  wx_ff, wy2_ff;
         // stage 3: blend along x
         logic [23:0]    lo3_ff, hi3_ff;
         logic [FW-1:0]  wy3_ff;
         // stage 4: distance between the rows
         logic [23:0]    lo4_ff, dif_ff;
         logic           dir_ff;
         logic [FW-1:0]  wy4_ff;
         // stage 5: scaled step
         logic [23:0]    lo5_ff, step_ff;
         logic           dir5_ff;
         logic [39:0]    step_p;
         // stage 6: octave sample
         logic [23:0]    v_ff;
         logic [NW-1:0]  sh;

         assign xs = vn2d_pkg::COORD_W'(req_x_coord << k);
         assign ys = vn2d_pkg::COORD_W'(req_y_coord << k);
         assign xi = xs[23:16];
         assign yi = ys[23:16];
         assign sx = xs[15:0];
         assign sy = ys[15:0];
         assign sqx_p = 32'(sx) * 32'(sx);
         assign sqy_p = 32'(sy) * 32'(sy);
         assign ra_in = vn2d_pkg::PERM_TABLE[IW'(yi + seed_ff)];
         assign rb_in = vn2d_pkg::PERM_TABLE[IW'(yi + seed_ff + IW'(1))];
         assign wx_p  = 34'(sqx_ff) * 34'(vn2d_pkg::SMOOTH_K - {1'b0, sx_ff, 1'b0});
         assign wy_p  = 34'(sqy_ff) * 34'(vn2d_pkg::SMOOTH_K - {1'b0, sy_ff, 1'b0});
         assign step_p = 40'(dif_ff) * 40'(wy4_ff);
         assign sh = NW'(ncl - NW'(k + 1));

         always_ff @(posedge clock) begin
            if (adv) begin
               xi_ff  <= xi;
               ra_ff  <= ra_in;
               rb_ff  <= rb_in;
               sx_ff  <= sx;
               sy_ff  <= sy;
               sqx_ff <= sqx_p[31:16];
               sqy_ff <= sqy_p[31:16];

               c00_ff <= vn2d_pkg::PERM_TABLE[IW'(ra_ff + xi_ff)];
               c10_ff <= vn2d_pkg::PERM_TABLE[IW'(ra_ff + xi_ff + IW'(1))];
               c01_ff <= vn2d_pkg::PERM_TABLE[IW'(rb_ff + xi_ff)];
               c11_ff <= vn2d_pkg::PERM_TABLE[IW'(rb_ff + xi_ff + IW'(1))];
               wx_ff  <= wx_p[31:16];
               wy2_ff <= wy_p[31:16];

               lo3_ff <= blend8(c00_ff, c10_ff, wx_ff);
               hi3_ff <= blend8(c01_ff, c11_ff, wx_ff);
               wy3_ff <= wy2_ff;

               dir_ff <= hi3_ff >= lo3_ff;
               dif_ff <= (hi3_ff >= lo3_ff) ? hi3_ff - lo3_ff : lo3_ff - hi3_ff;
               lo4_ff <= lo3_ff;
               wy4_ff <= wy3_ff;

               step_ff <= step_p[39:16];
               lo5_ff  <= lo4_ff;
               dir5_ff <= dir_ff;

               v_ff <= dir5_ff ? lo5_ff + step_ff : lo5_ff - step_ff;

               // octave k carries weight 2^(n-1-k); octaves beyond n drop out
               if (NW'(k) < ncl) begin
                  term_ff[k] <= AW'(v_ff) << sh;
               end else begin
                  term_ff[k] <= '0;
               end
            end
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            term_ff[k] <= '0;
         end
      end
   end

   // ---------------------------------------------------------------- sum tree
   logic [AW-1:0] grp_ff [NG];
   logic [AW-1:0] grp_in [NG];
   logic [AW-1:0] tot_in;

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = term_ff[4*g] + term_ff[4*g+1] + term_ff[4*g+2] + term_ff[4*g+3];
      end
      tot_in = '0;
      for (int g = 0; g < NG; g++) begin
         tot_in = tot_in + grp_ff[g];
      end
   end

   // ---------------------------------------------------------------- divider
   // restoring division of sum/256 by 2^n - 1, quotient below 2^16
   logic [RW-1:0]                 rem_ff [vn2d_pkg::DIV_STAGES+1];
   logic [vn2d_pkg::QUO_BITS-1:0] quo_ff [vn2d_pkg::DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         grp_ff    <= grp_in;
         rem_ff[0] <= tot_in[AW-1:8];
         quo_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < vn2d_pkg::DIV_STAGES; j++) begin : g_div
      localparam int B1 = vn2d_pkg::QUO_BITS - 1 - 2*j;
      localparam int B0 = B1 - 1;
      logic [RW-1:0]                 r1, r0;
      logic [vn2d_pkg::QUO_BITS-1:0] q1, q0;

      always_comb begin
         r1 = rem_ff[j];
         q1 = quo_ff[j];
         if (r1 >= (dvs << B1)) begin
            r1 = r1 - (dvs << B1);
            q1[B1] = 1'b1;
         end
         r0 = r1;
         q0 = q1;
         if (r0 >= (dvs << B0)) begin
            r0 = r0 - (dvs << B0);
            q0[B0] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1] <= r0;
            quo_ff[j+1] <= q0;
         end
      end
   end

   assign rsp_noise_value = quo_ff[vn2d_pkg::DIV_STAGES];

`ifndef SYNTHESIS
   a_take_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted word did not enter the pipeline");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rem_ff[vn2d_pkg::DIV_STAGES] < dvs)
      else $error("divider remainder not below divisor");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_noise_value <= 16'd65280)
      else $error("noise word above its bound");
`endif

endmodule

FILE: tb/value_noise_2d_octaves_core_test.sv
// Self-checking testbench for value_noise_2d_octaves_core: a directed table, then random
// coordinate words under several seed / octave settings, with random gaps on both channels.
// Depends on vn2d_pkg and the core; holds its own noise predictor.
`timescale 1ns / 1ps

module value_noise_2d_octaves_core_test;

   localparam logic [vn2d_pkg::CSR_IDX_W-1:0] CSR_SPARE2 = 2'd2;
   localparam logic [vn2d_pkg::CSR_IDX_W-1:0] CSR_SPARE3 = 2'd3;
   localparam int DRAIN_CYCLES = 24;   // pipeline is 17 deep

   typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      logic [vn2d_pkg::CSR_IDX_W-1:0]  idx;
      logic [vn2d_pkg::CSR_DATA_W-1:0] wdata;
      logic [vn2d_pkg::COORD_W-1:0]    x;
      logic [vn2d_pkg::COORD_W-1:0]    y;
      bit                              known;
      logic [vn2d_pkg::OUT_W-1:0]      noise;
   } stim_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [vn2d_pkg::COORD_W-1:0]    req_x_coord;
   logic [vn2d_pkg::COORD_W-1:0]    req_y_coord;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [vn2d_pkg::OUT_W-1:0]      rsp_noise_value;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [vn2d_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [vn2d_pkg::CSR_DATA_W-1:0] csr_wdata;

   logic [vn2d_pkg::SEED_W-1:0] cur_seed;
   logic [vn2d_pkg::OCT_W-1:0]  cur_octaves;
   logic [vn2d_pkg::OUT_W-1:0]  noise_expected [$];
   int                          mismatches;
   int                          words_sent;
   int                          words_checked;
   int                          stall_left;

   value_noise_2d_octaves_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic longint unsigned smooth_w(logic [vn2d_pkg::FRAC_W-1:0] s);
      longint unsigned sq;
      longint unsigned k;
      sq = (longint'(s) * longint'(s)) >> 16;
      k  = 196608 - 2 * longint'(s);
      return (sq * k) >> 16;
   endfunction

   function automatic longint unsigned lerp_toward(longint unsigned a, longint unsigned b,
                                                  longint unsigned w);
      if (b >= a) return a + (((b - a) * w) >> 16);
      return a - (((a - b) * w) >> 16);
   endfunction

   function automatic longint unsigned lattice_val(logic [7:0] xi, logic [7:0] yi,
                                                   logic [7:0] sd);
      logic [7:0] r;
      logic [7:0] row;
      r   = yi + sd;
      row = vn2d_pkg::PERM_TABLE[r];
      r   = row + xi;
      return longint'(vn2d_pkg::PERM_TABLE[r]) << 16;
   endfunction

   function automatic longint unsigned octave_val(logic [vn2d_pkg::COORD_W-1:0] x,
                                                  logic [vn2d_pkg::COORD_W-1:0] y,
                                                  logic [7:0] sd);
      logic [7:0]      xi;
      logic [7:0]      yi;
      logic [7:0]      xn;
      logic [7:0]      yn;
      longint unsigned wx;
      longint unsigned wy;
      longint unsigned lo;
      longint unsigned hi;
      xi = x[23:16];
      yi = y[23:16];
      xn = xi + 8'd1;
      yn = yi + 8'd1;
      wx = smooth_w(x[15:0]);
      wy = smooth_w(y[15:0]);
      lo = lerp_toward(lattice_val(xi, yi, sd), lattice_val(xn, yi, sd), wx);
      hi = lerp_toward(lattice_val(xi, yn, sd), lattice_val(xn, yn, sd), wx);
      return lerp_toward(lo, hi, wy);
   endfunction

   function automatic logic [vn2d_pkg::OUT_W-1:0] noise_predict(
         logic [vn2d_pkg::COORD_W-1:0] x, logic [vn2d_pkg::COORD_W-1:0] y,
         logic [7:0] sd, logic [3:0] oc);
      int unsigned     n;
      longint unsigned acc;
      longint unsigned res;
      n = (oc == 0) ? 1 : (oc > vn2d_pkg::MAX_OCTAVES) ? vn2d_pkg::MAX_OCTAVES : oc;
      acc = 0;
      for (int k = 0; k < n; k++) begin
         acc += octave_val(x, y, sd) << (n - 1 - k);
         x = {x[vn2d_pkg::COORD_W-2:0], 1'b0};
         y = {y[vn2d_pkg::COORD_W-2:0], 1'b0};
      end
      res = acc / (256 * ((longint'(1) << n) - 1));
      if (res > 65535) res = 65535;
      return res[vn2d_pkg::OUT_W-1:0];
   endfunction

   // ---------------- result side ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (noise_expected.size() == 0) begin
               $error("noise_value: unexpected word, actual %0d", rsp_noise_value);
               mismatches++;
            end else begin
               if (rsp_noise_value !== noise_expected[0]) begin
                  $error("noise_value: expected %0d, actual %0d",
                         noise_expected[0], rsp_noise_value);
                  mismatches++;
               end
               void'(noise_expected.pop_front());
               words_checked++;
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 99) < 4) begin
            rsp_ready <= 1'b0;
            stall_left <= $urandom_range(10, 40);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < 75);
         end
      end
   end

   // ---------------- request side ----------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_sample(logic [vn2d_pkg::COORD_W-1:0] x,
                              logic [vn2d_pkg::COORD_W-1:0] y,
                              bit known, logic [vn2d_pkg::OUT_W-1:0] noise);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (!req_ready);
      noise_expected.push_back(known ? noise : noise_predict(x, y, cur_seed, cur_octaves));
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [vn2d_pkg::CSR_IDX_W-1:0] idx,
                            logic [vn2d_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == vn2d_pkg::CSR_SEED) cur_seed = data;
      else if (idx == vn2d_pkg::CSR_OCTAVES) cur_octaves = data[vn2d_pkg::OCT_W-1:0];
   endtask

   function automatic logic [vn2d_pkg::COORD_W-1:0] rand_coord();
      logic [vn2d_pkg::COORD_W-1:0] c;
      c = vn2d_pkg::COORD_W'($urandom());
      case ($urandom_range(0, 9))
         0: c[15:0] = 16'h0000;
         1: c[15:0] = 16'hFFFF;
         2: c[23:16] = 8'hFF;
         3: c = {8'hFF, 16'hFFFF};
         default: ;
      endcase
      return c;
   endfunction

   // directed words; the integer lattice point (0,0) with seed 0 gives
   // table[table[0]] in every octave, so the result is that entry times 256
   stim_row_type directed [] = '{
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'h000000, 24'h000000, 1'b1, 16'd10752},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 16'd0},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'h000000, 24'hFFFFFF, 1'b0, 16'd0},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'h00FFFF, 24'h008000, 1'b0, 16'd0},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'hFF0000, 24'hFF0000, 1'b0, 16'd0},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'hFF8000, 24'h7F4000, 1'b0, 16'd0},
      '{ROW_CFG,    vn2d_pkg::CSR_OCTAVES, 8'h00, 24'h0, 24'h0, 1'b0, 16'd0},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'h000000, 24'h000000, 1'b1, 16'd10752},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'h123456, 24'hABCDEF, 1'b0, 16'd0},
      '{ROW_CFG,    vn2d_pkg::CSR_OCTAVES, 8'hFF, 24'h0, 24'h0, 1'b0, 16'd0},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'h000000, 24'h000000, 1'b1, 16'd10752},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'hFFFFFF, 24'h000001, 1'b0, 16'd0},
      '{ROW_CFG,    vn2d_pkg::CSR_SEED, 8'hFF, 24'h0, 24'h0, 1'b0, 16'd0},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'hFF0000, 24'hFFFFFF, 1'b0, 16'd0},
      '{ROW_CFG,    CSR_SPARE2, 8'h55, 24'h0, 24'h0, 1'b0, 16'd0},
      '{ROW_CFG,    CSR_SPARE3, 8'hAA, 24'h0, 24'h0, 1'b0, 16'd0},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'h80FFFF, 24'h01FFFF, 1'b0, 16'd0},
      '{ROW_CFG,    vn2d_pkg::CSR_OCTAVES, 8'hF1, 24'h0, 24'h0, 1'b0, 16'd0},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'h555555, 24'hAAAAAA, 1'b0, 16'd0},
      '{ROW_CFG,    vn2d_pkg::CSR_OCTAVES, 8'h08, 24'h0, 24'h0, 1'b0, 16'd0},
      '{ROW_SAMPLE, vn2d_pkg::CSR_SEED, 8'h00, 24'hAAAAAA, 24'h555555, 1'b0, 16'd0}
   };

   initial begin
      logic [7:0] seeds [6];
      logic [7:0] octs [6];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_x_coord = '0;
      req_y_coord = '0;
      csr_valid   = 1'b0;
      csr_index   = vn2d_pkg::CSR_SEED;
      csr_wdata   = '0;
      cur_seed    = vn2d_pkg::SEED_RESET;
      cur_octaves = vn2d_pkg::OCT_RESET;
      mismatches  = 0;
      words_sent  = 0;
      words_checked = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CFG) begin
            drain();
            write_csr(directed[i].idx, directed[i].wdata);
         end else begin
            send_sample(directed[i].x, directed[i].y, directed[i].known, directed[i].noise);
         end
      end

      // settings per random phase: fixed ones with the extremes first, then random ones
      seeds = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'h00};
      octs  = '{8'h01, 8'h08, 8'h04, 8'h0F, 8'h00, 8'h00};
      seeds[4] = 8'($urandom());
      octs[4]  = 8'($urandom());
      seeds[5] = 8'($urandom());
      octs[5]  = 8'($urandom_range(1, 8));
      for (int p = 0; p < 6; p++) begin
         drain();   // sender holds off until every word is back
         write_csr(vn2d_pkg::CSR_SEED, seeds[p]);
         write_csr(vn2d_pkg::CSR_OCTAVES, octs[p]);
         if (p == 3) write_csr(CSR_SPARE2, vn2d_pkg::CSR_DATA_W'($urandom()));
         for (int i = 0; i < 75; i++) send_sample(rand_coord(), rand_coord(), 1'b0, '0);
      end
      drain();

      $display("Sent %0d coordinate words, checked %0d noise words", words_sent, words_checked);
      $display("over seeds 0..255, octave counts 0..15 and ignored register indexes");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
